// ===== rtl/rv32i_instruction_encoder_defines.svh =====
// Assertion macros for the RV32I instruction encoder checker.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef RV32I_INSTRUCTION_ENCODER_DEFINES_SVH
`define RV32I_INSTRUCTION_ENCODER_DEFINES_SVH

// Property checked on the rising clock edge, ignored while in reset
`define RVENC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on the rising clock edge, reset included
`define RVENC_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rvenc_pkg.sv =====
// Shared types and constants for the RV32I instruction encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rvenc_pkg;

  // Queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Capacity register and word counter
  localparam int               CAP_W     = 17;
  localparam logic [CAP_W-1:0] CAP_RESET = 17'd1024;

  // Major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;

  // One queued request: up to two words
  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic        two;
  } q_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rvenc_front.sv =====
// Front end: accepts requests and encodes them into one or two words.
// Depends on rvenc_pkg; feeds rvenc_queue.
`default_nettype none

module rvenc_front import rvenc_pkg::*; (
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [5:0]         req_type,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         src1_reg,
  input  logic [4:0]         src2_reg,
  input  logic signed [31:0] immediate,
  input  q_stat_t            stat,
  output logic               push,
  output q_entry_t           push_entry
);

  // Request kinds: group boundaries and single kinds
  localparam logic [5:0] KIND_R_LAST   = 6'd9;
  localparam logic [5:0] KIND_I_FIRST  = 6'd10;
  localparam logic [5:0] KIND_I_LAST   = 6'd15;
  localparam logic [5:0] KIND_SLLI     = 6'd16;
  localparam logic [5:0] KIND_SRLI     = 6'd17;
  localparam logic [5:0] KIND_SRAI     = 6'd18;
  localparam logic [5:0] KIND_LD_FIRST = 6'd19;
  localparam logic [5:0] KIND_LD_LAST  = 6'd23;
  localparam logic [5:0] KIND_ST_FIRST = 6'd24;
  localparam logic [5:0] KIND_ST_LAST  = 6'd26;
  localparam logic [5:0] KIND_BR_FIRST = 6'd27;
  localparam logic [5:0] KIND_BR_LAST  = 6'd32;
  localparam logic [5:0] KIND_LUI      = 6'd33;
  localparam logic [5:0] KIND_AUIPC    = 6'd34;
  localparam logic [5:0] KIND_JAL      = 6'd35;
  localparam logic [5:0] KIND_JALR     = 6'd36;
  localparam logic [5:0] KIND_LI       = 6'd37;

  localparam logic [31:0] LI_ROUND = 32'h0000_0800;
  localparam logic [2:0]  F3_ADD   = 3'd0;
  localparam logic [2:0]  F3_SLL   = 3'd1;
  localparam logic [2:0]  F3_SR    = 3'd5;
  localparam logic [6:0]  F7_ALT   = 7'h20;

  // funct3 of the R-type ops: add sub and or xor sll srl sra slt sltu
  function automatic logic [2:0] r_f3(input logic [3:0] idx);
    logic [2:0] f;
    unique case (idx)
      4'd0, 4'd1: f = 3'd0;
      4'd2:       f = 3'd7;
      4'd3:       f = 3'd6;
      4'd4:       f = 3'd4;
      4'd5:       f = 3'd1;
      4'd6, 4'd7: f = 3'd5;
      4'd8:       f = 3'd2;
      4'd9:       f = 3'd3;
      default:    f = 3'd0;
    endcase
    return f;
  endfunction

  // sub and sra carry the alternate funct7
  function automatic logic [6:0] r_f7(input logic [3:0] idx);
    return (idx == 4'd1 || idx == 4'd7) ? F7_ALT : 7'h00;
  endfunction

  // addi andi ori xori slti sltiu
  function automatic logic [2:0] i_f3(input logic [2:0] idx);
    logic [2:0] f;
    unique case (idx)
      3'd0:    f = 3'd0;
      3'd1:    f = 3'd7;
      3'd2:    f = 3'd6;
      3'd3:    f = 3'd4;
      3'd4:    f = 3'd2;
      3'd5:    f = 3'd3;
      default: f = 3'd0;
    endcase
    return f;
  endfunction

  // lb lbu lh lhu lw
  function automatic logic [2:0] ld_f3(input logic [2:0] idx);
    logic [2:0] f;
    unique case (idx)
      3'd0:    f = 3'd0;
      3'd1:    f = 3'd4;
      3'd2:    f = 3'd1;
      3'd3:    f = 3'd5;
      3'd4:    f = 3'd2;
      default: f = 3'd0;
    endcase
    return f;
  endfunction

  // beq bne blt bge bltu bgeu
  function automatic logic [2:0] br_f3(input logic [2:0] idx);
    logic [2:0] f;
    unique case (idx)
      3'd0:    f = 3'd0;
      3'd1:    f = 3'd1;
      3'd2:    f = 3'd4;
      3'd3:    f = 3'd5;
      3'd4:    f = 3'd6;
      3'd5:    f = 3'd7;
      default: f = 3'd0;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [11:0] imm12);
    return {imm12, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_u(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [19:0] upper);
    return {upper, rd, op};
  endfunction

  logic [31:0] imm;
  logic [31:0] li_sum;
  logic [5:0]  off_i;
  logic [5:0]  off_ld;
  logic [5:0]  off_st;
  logic [5:0]  off_br;
  logic        known;
  logic [31:0] word0;
  logic        two;

  assign imm    = $unsigned(immediate);
  assign li_sum = imm + LI_ROUND;
  assign off_i  = req_type - KIND_I_FIRST;
  assign off_ld = req_type - KIND_LD_FIRST;
  assign off_st = req_type - KIND_ST_FIRST;
  assign off_br = req_type - KIND_BR_FIRST;

  // Encode by kind group
  always_comb begin
    known = 1'b1;
    two   = 1'b0;
    word0 = '0;
    priority if (req_type <= KIND_R_LAST) begin
      word0 = {r_f7(req_type[3:0]), src2_reg, src1_reg, r_f3(req_type[3:0]),
               dest_reg, OPC_REG};
    end else if (req_type <= KIND_I_LAST) begin
      word0 = enc_i(OPC_IMM, dest_reg, i_f3(off_i[2:0]), src1_reg, imm[11:0]);
    end else if (req_type == KIND_SLLI) begin
      word0 = enc_i(OPC_IMM, dest_reg, F3_SLL, src1_reg, {7'b0, imm[4:0]});
    end else if (req_type == KIND_SRLI) begin
      word0 = enc_i(OPC_IMM, dest_reg, F3_SR, src1_reg, {7'b0, imm[4:0]});
    end else if (req_type == KIND_SRAI) begin
      word0 = enc_i(OPC_IMM, dest_reg, F3_SR, src1_reg, {2'b01, 5'b0, imm[4:0]});
    end else if (req_type <= KIND_LD_LAST) begin
      word0 = enc_i(OPC_LOAD, dest_reg, ld_f3(off_ld[2:0]), src1_reg, imm[11:0]);
    end else if (req_type <= KIND_ST_LAST) begin
      word0 = {imm[11:5], src2_reg, src1_reg, off_st[2:0], imm[4:0], OPC_STORE};
    end else if (req_type <= KIND_BR_LAST) begin
      word0 = {imm[12], imm[10:5], src2_reg, src1_reg, br_f3(off_br[2:0]),
               imm[4:1], imm[11], OPC_BRANCH};
    end else if (req_type == KIND_LUI) begin
      word0 = enc_u(OPC_LUI, dest_reg, imm[31:12]);
    end else if (req_type == KIND_AUIPC) begin
      word0 = enc_u(OPC_AUIPC, dest_reg, imm[31:12]);
    end else if (req_type == KIND_JAL) begin
      word0 = {imm[20], imm[10:1], imm[11], imm[19:12], dest_reg, OPC_JAL};
    end else if (req_type == KIND_JALR) begin
      word0 = enc_i(OPC_JALR, dest_reg, F3_ADD, src1_reg, imm[11:0]);
    end else if (req_type == KIND_LI) begin
      // fits in 12 bits: single addi; otherwise lui of the rounded upper part, plus an addi if imm[11:0] is nonzero
      if (li_sum[31:12] == 20'd0) begin
        word0 = enc_i(OPC_IMM, dest_reg, F3_ADD, 5'd0, imm[11:0]);
      end else begin
        word0 = enc_u(OPC_LUI, dest_reg, li_sum[31:12]);
        two   = |imm[11:0];
      end
    end else begin
      known = 1'b0;
    end
  end

  // Low part of li equals the low 12 bits of the immediate
  assign push_entry.word0 = word0;
  assign push_entry.word1 = enc_i(OPC_IMM, dest_reg, F3_ADD, dest_reg, imm[11:0]);
  assign push_entry.two   = two;

  // Accept while the queue has room; unknown kinds are dropped
  assign req_stall = stat.full;
  assign push      = req_valid && !stat.full && known;

endmodule

`default_nettype wire

// ===== rtl/rvenc_queue.sv =====
// Short queue of encoded requests between front and back.
// Depends on rvenc_pkg for the entry and status types.
`default_nettype none

module rvenc_queue import rvenc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

// ===== rtl/rvenc_back.sv =====
// Back end: emits queued words, tracks the buffer position against capacity.
// Depends on rvenc_pkg; drains rvenc_queue into the output register.
`default_nettype none

module rvenc_back import rvenc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CAP_W-1:0] cfg_data,
  input  q_entry_t         head,
  input  q_stat_t          stat,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [31:0]      instr_word,
  output logic             stored,
  output logic [CAP_W-1:0] word_position,
  output logic             last
);

  logic             phase;     // second word of a two-word entry pending
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] position;
  logic             slot_free;
  logic             emit;
  logic             emit_last;
  logic             fits;

  assign slot_free = !res_valid || !res_stall;
  assign emit      = slot_free && !stat.empty;
  assign emit_last = phase || !head.two;
  assign pop       = emit && emit_last;
  assign fits      = (position < capacity);

  // Control: valid, phase, counter and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      phase     <= 1'b0;
      capacity  <= CAP_RESET;
      position  <= '0;
    end else begin
      if (slot_free) begin
        res_valid <= emit;
      end
      if (emit) begin
        phase <= !emit_last;
      end
      if (cfg_write) begin
        capacity <= cfg_data;
        position <= '0;
      end else if (emit && fits) begin
        position <= position + CAP_W'(1);
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (emit) begin
      instr_word    <= phase ? head.word1 : head.word0;
      stored        <= fits;
      word_position <= position;
      last          <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rv32i_instruction_encoder.sv =====
// RV32I instruction encoder with a word counter against a buffer capacity.
//
// Request channel (req_valid / req_stall): one request word per accepted
// cycle, taken while req_valid is high and req_stall is low. Unknown kinds
// are taken and produce nothing.
// Result channel (res_valid / res_stall): one encoded instruction per cycle,
// with stored, word_position and last. Held steady while res_stall is high.
// Config channel (cfg_valid / cfg_ready, ready always high): writes the
// capacity and restarts the position at zero; write only while idle.
// Path: a taken request is written into the front/back queue, and its word
// is then loaded into the output register.
// Throughput: one word per cycle while res_stall is low, so one request per
// cycle; a two-word li sends its lui, then its addi, through the single output register.
// The front keeps taking requests until the front/back queue is full, so a
// stall on the result side reaches req_stall after the queue fills.
// Reset: capacity 1024, position zero, queue and output empty.
`default_nettype none

module rv32i_instruction_encoder import rvenc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [5:0]         req_type,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         src1_reg,
  input  logic [4:0]         src2_reg,
  input  logic signed [31:0] immediate,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [31:0]        instr_word,
  output logic               stored,
  output logic [CAP_W-1:0]   word_position,
  output logic               last
);

  q_stat_t  stat;
  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;

  // Capacity writes always taken
  assign cfg_ready = 1'b1;

  rvenc_front u_front (
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .dest_reg   (dest_reg),
    .src1_reg   (src1_reg),
    .src2_reg   (src2_reg),
    .immediate  (immediate),
    .stat       (stat),
    .push       (push),
    .push_entry (push_entry)
  );

  rvenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  rvenc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .instr_word    (instr_word),
    .stored        (stored),
    .word_position (word_position),
    .last          (last)
  );

endmodule

`default_nettype wire

// ===== rtl/rvenc_checker.sv =====
// Port-level checks for rv32i_instruction_encoder, bound to the top level.
// Depends on rvenc_pkg and rv32i_instruction_encoder_defines.svh.
`include "rv32i_instruction_encoder_defines.svh"
`default_nettype none

module rvenc_checker import rvenc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               res_valid,
  input logic               res_stall,
  input logic [31:0]        instr_word,
  input logic               stored,
  input logic [CAP_W-1:0]   word_position,
  input logic               last
);

  // Output empty right after reset
  `RVENC_ASSERT_NORST(a_reset_empty, rst |=> !res_valid, "result valid after reset")

  // A stalled word holds
  `RVENC_ASSERT(a_stall_hold, res_valid && res_stall |=> res_valid && $stable(instr_word) && $stable(word_position) && $stable(last), "stalled word changed")

  // Only the lui of a two-word li is a non-final word
  `RVENC_ASSERT(a_first_is_lui, res_valid && !last |-> instr_word[6:0] == OPC_LUI, "non-final word is not lui")

  // The addi of a two-word li follows at once, one position on
  `RVENC_ASSERT(a_second_word, res_valid && !res_stall && stored && !last && !$past(cfg_valid && cfg_ready) |=> res_valid && last && instr_word[6:0] == OPC_IMM && word_position == $past(word_position) + 17'd1, "second li word missing or misplaced")

endmodule

bind rv32i_instruction_encoder rvenc_checker u_rvenc_checker (.*);

`default_nettype wire
